FILE: hdl/tqs_pkg.sv
// ---------------------------------------------------------------------------
// tqs_pkg
// Shared types and codes for the thread queue with identifier search.
// ---------------------------------------------------------------------------
package tqs_pkg;

	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_POP    = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_SEARCH = 3'd3;
	localparam logic [2:0] ACT_WAKE   = 3'd4;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_SEARCH = 3'd3;
	localparam logic [2:0] OP_WAKE   = 3'd4;
	localparam logic [2:0] OP_NONE   = 3'd5;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] thread_id;
		logic [15:0] pcb_handle;
		logic [15:0] thread_handle;
	} item_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] pcb_out;
		logic [15:0] thread_out;
		logic        wake;
		logic        last;
	} item_out_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] id;
		logic [15:0] pcb;
		logic [15:0] thread;
	} cmd_t;

endpackage

FILE: hdl/thread_queue_with_id_search.sv
// ---------------------------------------------------------------------------
// thread_queue_with_id_search
// Ordered thread queue with append, pop, remove/search by id and wake-all.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | tqs_pkg::item_in_t
//   out     | output    | out_valid / out_ready| tqs_pkg::item_out_t
//
// Append and unused actions, and any action on an empty queue, finish in the
// dispatch state; pop front reads the head entry once. Search and remove read
// entries one by one (registered memory read) until a hit, remove then moves each
// later entry up to close the gap; wake all reads and reports each entry woken.
// Two commands may wait in the queue behind the back part; results stall in
// the output register. Reset empties the queue, entries are not cleared.
// ---------------------------------------------------------------------------
module thread_queue_with_id_search #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tqs_pkg::item_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tqs_pkg::item_out_t out_data
);
	import tqs_pkg::*;

	logic push;
	cmd_t push_data;
	logic fifo_full;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	tqs_front #(
		.ID_BITS(ID_BITS)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.fifo_full(fifo_full),
		.push     (push),
		.push_data(push_data)
	);

	tqs_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (fifo_full),
		.pop      (cmd_pop),
		.not_empty(cmd_valid),
		.pop_data (cmd)
	);

	tqs_back #(
		.DEPTH  (DEPTH),
		.ID_BITS(ID_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

FILE: hdl/tqs_front.sv
// ---------------------------------------------------------------------------
// tqs_front
// Accepts input transfers and classifies them into queue commands.
// ---------------------------------------------------------------------------
module tqs_front #(
	parameter int ID_BITS = 16
) (
	input  logic             in_valid,
	output logic             in_ready,
	input  tqs_pkg::item_in_t in_data,
	input  logic             fifo_full,
	output logic             push,
	output tqs_pkg::cmd_t    push_data
);
	import tqs_pkg::*;

	localparam logic [15:0] ID_MASK = (ID_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << ID_BITS) - 32'd1);

	assign in_ready = !fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		push_data.id     = in_data.thread_id & ID_MASK;
		push_data.pcb    = in_data.pcb_handle;
		push_data.thread = in_data.thread_handle;
		unique case (in_data.action)
			ACT_APPEND: push_data.op = OP_APPEND;
			ACT_POP:    push_data.op = OP_POP;
			ACT_REMOVE: push_data.op = OP_REMOVE;
			ACT_SEARCH: push_data.op = OP_SEARCH;
			ACT_WAKE:   push_data.op = OP_WAKE;
			default:    push_data.op = OP_NONE;
		endcase
	end

endmodule

FILE: hdl/tqs_cmd_fifo.sv
// ---------------------------------------------------------------------------
// tqs_cmd_fifo
// Two-entry command queue between the front and back parts.
// ---------------------------------------------------------------------------
module tqs_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tqs_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output tqs_pkg::cmd_t pop_data
);
	import tqs_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: hdl/tqs_back.sv
// ---------------------------------------------------------------------------
// tqs_back
// Executes queue commands on the entry memory and drives the result register.
// ---------------------------------------------------------------------------
module tqs_back #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  tqs_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output tqs_pkg::item_out_t out_data
);
	import tqs_pkg::*;

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int SW  = CW + 1;
	localparam int SID = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int EW  = 32 + SID;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_SRD  = 3'd4;
	localparam logic [2:0] S_MV   = 3'd5;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(DEPTH))
			s = s - SW'(DEPTH);
		return AW'(s);
	endfunction

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rdata_q;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] head_q, head_d;
	cmd_t          cmd_q, cmd_d;
	logic          out_valid_q;
	item_out_t     out_q;

	logic          out_free;
	logic          emit;
	item_out_t     res;
	logic          wr_en;
	logic [CW-1:0] wr_off;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] wr_data;
	logic          last_idx;
	logic          hit;
	logic [15:0]   rd_pcb;
	logic [SID-1:0] rd_id;
	logic [15:0]   rd_thread;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign rd_pcb    = rdata_q[EW-1 -: 16];
	assign rd_id     = rdata_q[16 +: SID];
	assign rd_thread = rdata_q[15:0];
	assign last_idx  = ((idx_q + CW'(1)) == count_q);
	assign hit       = (rd_id == cmd_q.id[SID-1:0]);

	assign rd_addr = wrap_add(head_q, idx_q);
	assign wr_addr = wrap_add(head_q, wr_off);
	assign wr_data = (state_q == S_MV) ? rdata_q :
		{cmd_q.pcb, cmd_q.id[SID-1:0], cmd_q.thread};

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		count_d    = count_q;
		head_d     = head_q;
		cmd_d      = cmd_q;
		cmd_pop    = 1'b0;
		emit       = 1'b0;
		res        = '0;
		res.last   = 1'b1;
		wr_en      = 1'b0;
		wr_off     = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_d   = cmd;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				idx_d = '0;
				unique case (cmd_q.op)
					OP_APPEND: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (count_q == CW'(DEPTH)) begin
								res.status = STS_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
					end
					OP_NONE: begin
						if (out_free) begin
							emit       = 1'b1;
							res.status = STS_EMPTY;
							state_d    = S_IDLE;
						end
					end
					default: begin
						if (count_q != '0) begin
							state_d = S_RD;
						end else if (out_free) begin
							emit       = 1'b1;
							res.status = STS_EMPTY;
							state_d    = S_IDLE;
						end
					end
				endcase
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				unique case (cmd_q.op)
					OP_POP: begin
						if (out_free) begin
							emit        = 1'b1;
							res.pcb_out = rd_pcb;
							head_d      = wrap_add(head_q, CW'(1));
							count_d     = count_q - CW'(1);
							state_d     = S_IDLE;
						end
					end
					OP_WAKE: begin
						if (out_free) begin
							emit        = 1'b1;
							res.pcb_out = rd_pcb;
							res.wake    = 1'b1;
							res.last    = last_idx;
							if (last_idx) begin
								count_d = '0;
								state_d = S_IDLE;
							end else begin
								idx_d   = idx_q + CW'(1);
								state_d = S_RD;
							end
						end
					end
					default: begin
						if (hit) begin
							if (out_free) begin
								emit           = 1'b1;
								res.thread_out = rd_thread;
								if (cmd_q.op != OP_REMOVE) begin
									state_d = S_IDLE;
								end else if (last_idx) begin
									count_d = count_q - CW'(1);
									state_d = S_IDLE;
								end else begin
									idx_d   = idx_q + CW'(1);
									state_d = S_SRD;
								end
							end
						end else if (last_idx) begin
							if (out_free) begin
								emit       = 1'b1;
								res.status = STS_EMPTY;
								state_d    = S_IDLE;
							end
						end else begin
							idx_d   = idx_q + CW'(1);
							state_d = S_RD;
						end
					end
				endcase
			end
			S_SRD: state_d = S_MV;
			S_MV: begin
				wr_en  = 1'b1;
				wr_off = idx_q - CW'(1);
				if (last_idx) begin
					count_d = count_q - CW'(1);
					state_d = S_IDLE;
				end else begin
					idx_d   = idx_q + CW'(1);
					state_d = S_SRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
			head_q  <= head_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (emit)
			out_q <= res;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DISP && cmd_q.op == OP_APPEND && out_free &&
		 count_q != CW'(DEPTH)) |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not grow the queue");

	a_wake_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res.wake && res.last) |=> count_q == '0)
		else $error("queue not empty after final wake");

	a_shift_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MV) |-> (idx_q != '0 && idx_q < count_q))
		else $error("compaction index out of range");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == S_IDLE && cmd_valid))
		else $error("command taken while busy");

endmodule

FILE: tb/thread_queue_check.sv
// ---------------------------------------------------------------------------
// thread_queue_check
// Watches both channels of the thread queue. Every input transfer is played
// on a shadow queue, which yields the results the block owes; each output
// transfer is compared field by field with the oldest result still owed.
// ---------------------------------------------------------------------------
module thread_queue_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  tqs_pkg::item_in_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  tqs_pkg::item_out_t out_data,
	output int                 errors,
	output int                 pending
);
	import tqs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	logic [15:0] held_pcb[DEPTH];
	logic [15:0] held_id[DEPTH];
	logic [15:0] held_thread[DEPTH];
	int          held_count = 0;
	item_out_t   due_results[$];
	int          mismatch_count = 0;
	int          due_count = 0;

	assign errors  = mismatch_count;
	assign pending = due_count;

	task automatic report_mismatch(input string msg);
		$display("%t mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic owe(input logic [1:0] status, input logic [15:0] pcb,
			input logic [15:0] thr, input logic wake, input logic last);
		due_results.push_back('{status: status, pcb_out: pcb, thread_out: thr,
			wake: wake, last: last});
	endtask

	task automatic close_up(input int pos);
		int i;
		for (i = pos; i + 1 < held_count; i++) begin
			held_pcb[i]    = held_pcb[i + 1];
			held_id[i]     = held_id[i + 1];
			held_thread[i] = held_thread[i + 1];
		end
		held_count--;
	endtask

	task automatic advance_queue(input item_in_t it);
		int pos;
		int i;
		pos = -1;
		case (it.action)
			ACT_APPEND: begin
				if (held_count >= DEPTH) begin
					owe(STS_FULL, '0, '0, 1'b0, 1'b1);
				end else begin
					held_pcb[held_count]    = it.pcb_handle;
					held_id[held_count]     = it.thread_id;
					held_thread[held_count] = it.thread_handle;
					held_count++;
					owe(STS_OK, '0, '0, 1'b0, 1'b1);
				end
			end
			ACT_POP: begin
				if (held_count == 0) begin
					owe(STS_EMPTY, '0, '0, 1'b0, 1'b1);
				end else begin
					owe(STS_OK, held_pcb[0], '0, 1'b0, 1'b1);
					close_up(0);
				end
			end
			ACT_REMOVE, ACT_SEARCH: begin
				for (i = 0; i < held_count && pos < 0; i++)
					if (held_id[i] == it.thread_id)
						pos = i;
				if (pos < 0) begin
					owe(STS_EMPTY, '0, '0, 1'b0, 1'b1);
				end else begin
					owe(STS_OK, '0, held_thread[pos], 1'b0, 1'b1);
					if (it.action == ACT_REMOVE)
						close_up(pos);
				end
			end
			ACT_WAKE: begin
				if (held_count == 0)
					owe(STS_EMPTY, '0, '0, 1'b0, 1'b1);
				for (i = 0; i < held_count; i++)
					owe(STS_OK, held_pcb[i], '0, 1'b1, i == held_count - 1);
				held_count = 0;
			end
			default: begin
				owe(STS_EMPTY, '0, '0, 1'b0, 1'b1);
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic check_result(input item_out_t got);
		item_out_t want;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("result %p with nothing owed", got));
		end else begin
			want = due_results.pop_front();
			check_field("status", 16'(got.status), 16'(want.status));
			check_field("pcb_out", got.pcb_out, want.pcb_out);
			check_field("thread_out", got.thread_out, want.thread_out);
			check_field("wake", 16'(got.wake), 16'(want.wake));
			check_field("last", 16'(got.last), 16'(want.last));
		end
	endtask

	// results first: a result can never belong to an input taken on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (in_valid && in_ready)
				advance_queue(in_data);
			due_count <= due_results.size();
		end
	end

endmodule

FILE: tb/thread_queue_with_id_search_test.sv
// ---------------------------------------------------------------------------
// thread_queue_with_id_search_test
// Drives the thread queue with a directed run over the empty, full, duplicate
// and unused-action cases, then random queue traffic in fill and drain
// phases, with random stalls on both channels. Checking is done beside the
// block by thread_queue_check; this module makes stimulus and the verdict.
// ---------------------------------------------------------------------------
module thread_queue_with_id_search_test;
	import tqs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          QUEUE_DEPTH    = 16;
	localparam int          RANDOM_ITEMS   = 140;
	localparam int          CALM_ITEMS     = 40;
	localparam int          WATCHDOG_LIMIT = 3000;
	localparam int          DRAIN_CYCLES   = 120;
	localparam logic [2:0]  ACT_SPARE_LO   = 3'd5;
	localparam logic [2:0]  ACT_SPARE_HI   = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	item_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	item_out_t out_data;
	int        errors;
	int        pending;
	bit        calm = 1'b0;
	int        stall_left = 0;
	logic [15:0] id_pool[8];

	thread_queue_with_id_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	thread_queue_check queue_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send(input logic [2:0] act, input logic [15:0] id,
			input logic [15:0] pcb, input logic [15:0] thr);
		in_data  <= '{action: act, thread_id: id, pcb_handle: pcb, thread_handle: thr};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int i;
		int useful;
		int r;
		bit filling;
		logic [2:0]  act;
		logic [15:0] id;

		for (i = 0; i < 8; i++)
			id_pool[i] = 16'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue and unused codes
		send(ACT_POP, 16'h0000, 16'h0000, 16'h0000);
		send(ACT_WAKE, 16'h0000, 16'h0000, 16'h0000);
		send(ACT_SEARCH, 16'hFFFF, 16'h0000, 16'h0000);
		send(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(ACT_SPARE_HI, 16'h0000, 16'h0000, 16'h0000);

		// fill with repeated ids, then one append too many
		send(ACT_APPEND, 16'h0000, 16'h0000, 16'h0000);
		send(ACT_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (i = 2; i < QUEUE_DEPTH; i++)
			send(ACT_APPEND, 16'h0100 + 16'(i % 4), 16'($urandom), 16'($urandom));
		send(ACT_APPEND, 16'h5A5A, 16'h1234, 16'h4321);

		send(ACT_SEARCH, 16'h0102, 16'h0000, 16'h0000);
		send(ACT_REMOVE, 16'h0101, 16'h0000, 16'h0000);
		send(ACT_REMOVE, 16'h1234, 16'h0000, 16'h0000);
		send(ACT_POP, 16'h0000, 16'h0000, 16'h0000);
		send(ACT_WAKE, 16'h0000, 16'h0000, 16'h0000);
		wait_drained();

		useful = 0;
		filling = 1'b1;
		while (useful < RANDOM_ITEMS) begin
			calm = (useful >= RANDOM_ITEMS - CALM_ITEMS);
			if (useful % 30 == 0)
				filling = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (filling)
				act = r < 70 ? ACT_APPEND : r < 76 ? ACT_POP : r < 86 ? ACT_REMOVE :
					r < 96 ? ACT_SEARCH : r < 98 ? ACT_WAKE : ACT_SPARE_LO;
			else
				act = r < 30 ? ACT_APPEND : r < 45 ? ACT_POP : r < 65 ? ACT_REMOVE :
					r < 85 ? ACT_SEARCH : r < 93 ? ACT_WAKE : ACT_SPARE_LO;
			if (act == ACT_SPARE_LO)
				act = 3'($urandom_range(int'(ACT_SPARE_LO), int'(ACT_SPARE_HI)));
			else
				useful++;
			id = $urandom_range(0, 3) == 0 ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
			send(act, id, 16'($urandom), 16'($urandom));
			if (useful == RANDOM_ITEMS / 2 && act <= ACT_WAKE)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
